### rtl/r2p_pkg.sv
// r2p_pkg: shared types, constants and the arctangent table for the
// rectangular to polar converter. No dependencies.
package r2p_pkg;

	// Block configuration
	localparam int DATA_WIDTH      = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ITERATIONS      = 16;

	// Port field width, fixed by the interface
	localparam int IO_W = 16;

	// Internal fixed-point formats
	localparam int GUARD_BITS = 40 - DATA_WIDTH;
	localparam int EXT_W      = DATA_WIDTH + 1;   // holds the negated minimum
	localparam int XY_W       = 43;               // x, y scaled to 2^40, plus growth
	localparam int Z_FRAC     = 20;
	localparam int Z_W        = 32;
	localparam int GAIN_FRAC  = 20;
	localparam int GAIN_W     = 20;
	localparam logic [GAIN_W-1:0] GAIN_INV = GAIN_W'(636751);
	localparam int MAG_SH     = GAIN_FRAC + GUARD_BITS;
	localparam int ANG_SH     = Z_FRAC - ANGLE_FRAC_BITS;
	localparam int ITER_IDX_W = $clog2(ITERATIONS);

	// Gain multiply operand split
	localparam int SPLIT_W = 21;
	localparam int PROD_W  = SPLIT_W + GAIN_W;

	// Angle constants in the output scale and in the z scale
	localparam int ANG_W = 24;
	localparam logic signed [ANG_W-1:0] ANG_FULL = ANG_W'(180 <<< ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] ANG_QUAD = ANG_W'(90 <<< ANGLE_FRAC_BITS);
	localparam logic signed [Z_W-1:0]   Z_HALF_TURN = Z_W'(180 <<< Z_FRAC);
	localparam logic signed [Z_W-1:0]   Z_ROUND = Z_W'(1 <<< (ANG_SH - 1));
	localparam logic [63:0] MAG_ROUND = 64'(1) << (MAG_SH - 1);
	localparam logic [63:0] MAG_MAX   = (64'(1) << DATA_WIDTH) - 64'(1);

	// Sign position of the input after taking DATA_WIDTH bits
	localparam int SIGN_IDX = (DATA_WIDTH <= IO_W) ? DATA_WIDTH - 1 : IO_W - 1;
	localparam bit SIGN_EN  = (DATA_WIDTH <= IO_W);

	typedef struct packed {
		logic signed [IO_W-1:0] real_part;
		logic signed [IO_W-1:0] imag_part;
	} sample_t;

	typedef struct packed {
		logic [IO_W-1:0]        magnitude;
		logic signed [IO_W-1:0] angle_deg;
	} polar_t;

	// Working set carried along the rotation chain
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   bypass;    // an axis input, result known up front
		logic [IO_W-1:0]        byp_mag;
		logic [IO_W-1:0]        byp_ang;
	} cord_t;

	// Take the low DATA_WIDTH bits of a port field, sign-extended
	function automatic logic signed [EXT_W-1:0] take_input(input logic [IO_W-1:0] raw);
		logic signed [EXT_W-1:0] v;
		for (int k = 0; k < EXT_W; k++) begin
			if (k < DATA_WIDTH && k < IO_W) begin
				v[k] = raw[k];
			end else if (k >= DATA_WIDTH) begin
				v[k] = SIGN_EN ? raw[SIGN_IDX] : 1'b0;
			end else begin
				v[k] = 1'b0;
			end
		end
		return v;
	endfunction

	// atan(2^-i) in degrees, scaled by 2^20 and rounded
	function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_IDX_W-1:0] idx);
		int unsigned k;
		int          r;
		k = int'(idx);
		case (k)
			0:  r = 47185920;
			1:  r = 27855475;
			2:  r = 14718068;
			3:  r = 7471121;
			4:  r = 3750058;
			5:  r = 1876857;
			6:  r = 938658;
			7:  r = 469357;
			8:  r = 234682;
			9:  r = 117342;
			10: r = 58671;
			11: r = 29335;
			12: r = 14668;
			13: r = 7334;
			14: r = 3667;
			15: r = 1833;
			16: r = 917;
			17: r = 458;
			18: r = 229;
			19: r = 115;
			20: r = 57;
			21: r = 29;
			22: r = 14;
			23: r = 7;
			24: r = 4;
			25: r = 2;
			26: r = 1;
			default: r = 0;
		endcase
		return Z_W'(r);
	endfunction

endpackage

### rtl/r2p_cell.sv
// r2p_cell: one CORDIC vectoring micro-rotation with its pipeline register
// and handshake. Depends on r2p_pkg.
module r2p_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [r2p_pkg::ITER_IDX_W-1:0] stage_idx,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  r2p_pkg::cord_t               up_data,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output r2p_pkg::cord_t               dn_data
);
	import r2p_pkg::*;

	logic  valid_s1;
	cord_t data_s1;
	cord_t rot;
	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W-1:0]  step;

	// Stage takes a request when empty or when its own request leaves
	assign up_ready = !valid_s1 || dn_ready;

	// Micro-rotation towards the x axis
	always_comb begin
		dx   = up_data.y >>> stage_idx;
		dy   = up_data.x >>> stage_idx;
		step = atan_step(stage_idx);
		rot  = up_data;
		if (up_data.y < 0) begin
			rot.x = up_data.x - dx;
			rot.y = up_data.y + dy;
			rot.z = up_data.z - step;
		end else begin
			rot.x = up_data.x + dx;
			rot.y = up_data.y - dy;
			rot.z = up_data.z + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= rot;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

### rtl/r2p_post.sv
// r2p_post: gain compensation, rounding and clamping after the rotation
// chain, two pipeline stages. Depends on r2p_pkg.
module r2p_post (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  r2p_pkg::cord_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output r2p_pkg::polar_t dn_data
);
	import r2p_pkg::*;

	logic                valid_s1, valid_s2;
	logic                ready_s1;
	logic [PROD_W-1:0]   p_hi_s1, p_lo_s1;
	logic                bypass_s1;
	logic [IO_W-1:0]     byp_mag_s1;
	logic [IO_W-1:0]     ang_s1;
	polar_t              res_s2;

	logic [2*SPLIT_W-1:0]   x_u;
	logic signed [Z_W-1:0]  z_rnd;
	logic signed [Z_W-1:0]  z_sh;
	logic signed [ANG_W-1:0] ang_c;
	logic [IO_W-1:0]        ang_next;
	logic [63:0]            mag_sum;
	logic [63:0]            mag_full;
	logic [IO_W-1:0]        mag_next;

	assign ready_s1 = !valid_s2 || dn_ready;
	assign up_ready = !valid_s1 || ready_s1;

	// Stage 1: split the gain multiply, round and clamp the angle
	always_comb begin
		x_u      = up_data.x[2*SPLIT_W-1:0];   // x is never negative
		z_rnd    = up_data.z + Z_ROUND;
		z_sh     = z_rnd >>> ANG_SH;
		ang_c    = ANG_W'(z_sh);
		if (ang_c > ANG_FULL) begin
			ang_c = ANG_FULL;
		end else if (ang_c < -ANG_FULL) begin
			ang_c = -ANG_FULL;
		end
		ang_next = up_data.bypass ? up_data.byp_ang : ang_c[IO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			p_hi_s1    <= x_u[2*SPLIT_W-1:SPLIT_W] * GAIN_INV;
			p_lo_s1    <= x_u[SPLIT_W-1:0] * GAIN_INV;
			bypass_s1  <= up_data.bypass;
			byp_mag_s1 <= up_data.byp_mag;
			ang_s1     <= ang_next;
		end
	end

	// Stage 2: join the partial products, round and saturate the magnitude
	always_comb begin
		mag_sum  = (64'(p_hi_s1) << SPLIT_W) + 64'(p_lo_s1) + MAG_ROUND;
		mag_full = mag_sum >> MAG_SH;
		mag_next = (mag_full > MAG_MAX) ? MAG_MAX[IO_W-1:0] : mag_full[IO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			res_s2.magnitude <= bypass_s1 ? byp_mag_s1 : mag_next;
			res_s2.angle_deg <= ang_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = res_s2;

endmodule

### rtl/rect_to_polar_converter.sv
// rect_to_polar_converter: top level, pre-rotation stage, chain of CORDIC
// cells and output stages. Depends on r2p_pkg, r2p_cell and r2p_post.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  sample  | sample_valid, sample_ready, sample   | real_part, imag_part in
//  polar   | polar_valid, polar_ready, polar      | magnitude, angle_deg out
//
// One request per clock when the output is taken. A request passes through the
// pre-rotation stage, one cell per CORDIC iteration and two output stages for
// the split gain multiply.
// Every stage has its own valid bit and takes a request whenever it is empty
// or its content moves on, so bubbles close up while the output stalls.
// Reset clears the valid bits only; the data registers are not reset.
module rect_to_polar_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  r2p_pkg::sample_t sample,
	output logic             polar_valid,
	input  logic             polar_ready,
	output r2p_pkg::polar_t  polar
);
	import r2p_pkg::*;

	logic signed [EXT_W-1:0] re, im, re_abs, im_abs;
	logic                    neg;
	cord_t                   pre_next;

	logic  pre_valid_s1;
	cord_t pre_s1;

	logic  chain_valid [ITERATIONS+1];
	logic  chain_ready [ITERATIONS+1];
	cord_t chain_data  [ITERATIONS+1];

	// Pre-rotation: fold the left half plane and flag axis inputs
	always_comb begin
		re     = take_input(sample.real_part);
		im     = take_input(sample.imag_part);
		re_abs = (re < 0) ? -re : re;
		im_abs = (im < 0) ? -im : im;
		neg    = (re < 0);

		pre_next.x = XY_W'(neg ? -re : re) <<< GUARD_BITS;
		pre_next.y = XY_W'(neg ? -im : im) <<< GUARD_BITS;
		if (!neg) begin
			pre_next.z = '0;
		end else if (im >= 0) begin
			pre_next.z = Z_HALF_TURN;
		end else begin
			pre_next.z = -Z_HALF_TURN;
		end

		pre_next.bypass = (im == 0) || (re == 0);
		if (im == 0) begin
			pre_next.byp_mag = re_abs[IO_W-1:0];
			pre_next.byp_ang = neg ? ANG_FULL[IO_W-1:0] : '0;
		end else begin
			pre_next.byp_mag = im_abs[IO_W-1:0];
			pre_next.byp_ang = (im > 0) ? ANG_QUAD[IO_W-1:0] : IO_W'(-ANG_QUAD);
		end
	end

	assign sample_ready = !pre_valid_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			pre_valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			pre_s1 <= pre_next;
		end
	end

	assign chain_valid[0] = pre_valid_s1;
	assign chain_data[0]  = pre_s1;

	// One cell per iteration
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		r2p_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (ITER_IDX_W'(i)),
			.up_valid  (chain_valid[i]),
			.up_ready  (chain_ready[i]),
			.up_data   (chain_data[i]),
			.dn_valid  (chain_valid[i+1]),
			.dn_ready  (chain_ready[i+1]),
			.dn_data   (chain_data[i+1])
		);
	end

	// Gain compensation and output register
	r2p_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[ITERATIONS]),
		.up_ready (chain_ready[ITERATIONS]),
		.up_data  (chain_data[ITERATIONS]),
		.dn_valid (polar_valid),
		.dn_ready (polar_ready),
		.dn_data  (polar)
	);

	// An empty front stage never refuses a request
	a_front_open: assert property (@(posedge clk) disable iff (!arst_n)
		!pre_valid_s1 |-> sample_ready)
		else $error("front stage empty but sample_ready low");

	// A request leaving the front stage lands in the first cell
	a_front_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pre_valid_s1 && chain_ready[0]) |=> chain_valid[1])
		else $error("request lost between front stage and first cell");

	// Vectoring leaves x non-negative at the end of the rotation chain
	a_x_positive: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[ITERATIONS] |-> !chain_data[ITERATIONS].x[XY_W-1])
		else $error("negative x at end of rotation chain");

endmodule

### bench/rect_to_polar_converter_test.sv
// rect_to_polar_converter_test: self-checking bench for the rectangular to polar converter.
// Fixed-point CORDIC prediction, scoreboard and random flow control on both channels.
// Depends on r2p_pkg and rect_to_polar_converter.
`timescale 1ns / 1ps

module rect_to_polar_converter_test;
	import r2p_pkg::*;

	localparam int  LATENCY     = ITERATIONS + 3;
	localparam int  CYCLE_LIMIT = 600000;
	localparam int  RANDOM_REQS = 1000;
	// Angle in degrees scaled by 2^20, magnitude gain 1/K scaled by 2^20
	localparam int  ZF          = 20;
	localparam int  SCALE_SH    = 40 - DATA_WIDTH;
	localparam int  GAIN_SH     = 20 + SCALE_SH;
	localparam longint GAIN_RECIP = 636751;

	typedef struct packed {
		sample_t req;
		polar_t  want;
	} polar_due_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    polar_valid;
	logic    polar_ready  = 1'b0;
	polar_t  polar;

	polar_due_t  pending_polar[$];
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;

	// arctangent of 2^-i in degrees, scaled by 2^20
	longint atan_q20 [0:31] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7,
		4, 2, 1, 0, 0, 0, 0, 0
	};

	rect_to_polar_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.polar_valid  (polar_valid),
		.polar_ready  (polar_ready),
		.polar        (polar)
	);

	always #4 clk = ~clk;

	// Low DATA_WIDTH bits of a port field, sign-extended
	function automatic longint part_value(input logic [IO_W-1:0] raw);
		longint v;
		v = longint'({48'd0, raw}) & ((longint'(1) << DATA_WIDTH) - 1);
		if (v[DATA_WIDTH-1])
			v = v - (longint'(1) << DATA_WIDTH);
		return v;
	endfunction

	// Magnitude and angle of one sample, bit exact with the fixed-point CORDIC
	function automatic polar_t to_polar(input sample_t s);
		longint      re, im, x, y, z, dx, dy, ang, full, step;
		logic [63:0] xu, mag;
		int          sh;
		polar_t      r;
		re   = part_value(s.real_part);
		im   = part_value(s.imag_part);
		full = longint'(180) << ANGLE_FRAC_BITS;
		if (im == 0) begin
			mag = (re < 0) ? 64'(-re) : 64'(re);
			ang = (re < 0) ? full : 0;
		end else if (re == 0) begin
			mag = (im < 0) ? 64'(-im) : 64'(im);
			ang = (im > 0) ? (longint'(90) << ANGLE_FRAC_BITS)
			               : -(longint'(90) << ANGLE_FRAC_BITS);
		end else begin
			// left half plane: turn by 180 degrees first
			if (re < 0) begin
				x = -re <<< SCALE_SH;
				y = -im <<< SCALE_SH;
				z = (im >= 0) ? (longint'(180) << ZF) : -(longint'(180) << ZF);
			end else begin
				x = re <<< SCALE_SH;
				y = im <<< SCALE_SH;
				z = 0;
			end
			for (int i = 0; i < ITERATIONS; i++) begin
				step = (i < 32) ? atan_q20[i] : 0;
				sh   = (i < 63) ? i : 63;
				dx   = y >>> sh;
				dy   = x >>> sh;
				if (y < 0) begin
					x = x - dx;
					y = y + dy;
					z = z - step;
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + step;
				end
			end
			xu  = x;
			mag = (xu * 64'(GAIN_RECIP) + (64'd1 << (GAIN_SH - 1))) >> GAIN_SH;
			if (mag > (64'd1 << DATA_WIDTH) - 64'd1)
				mag = (64'd1 << DATA_WIDTH) - 64'd1;
			ang = (z + (longint'(1) << (ZF - ANGLE_FRAC_BITS - 1))) >>> (ZF - ANGLE_FRAC_BITS);
			if (ang > full)
				ang = full;
			if (ang < -full)
				ang = -full;
		end
		r.magnitude = mag[IO_W-1:0];
		r.angle_deg = ang[IO_W-1:0];
		return r;
	endfunction

	// Sender idle gap: mostly none, some short, a few long
	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drive one request, hold it until taken, then log what it should produce
	task automatic send_sample(input sample_t s, input int unsigned gap);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		pending_polar.push_back('{req: s, want: to_polar(s)});
	endtask

	task automatic send_pair(input int re, input int im);
		sample_t s;
		s.real_part = 16'(re);
		s.imag_part = 16'(im);
		send_sample(s, idle_gap());
	endtask

	// Zero and the four half axes, where the result is known without rotation
	task automatic test_axes();
		send_pair(0, 0);
		send_pair(32767, 0);
		send_pair(1, 0);
		send_pair(-1, 0);
		send_pair(-32768, 0);
		send_pair(0, 32767);
		send_pair(0, 1);
		send_pair(0, -1);
		send_pair(0, -32768);
	endtask

	// Full-scale corners and unit diagonals in every quadrant
	task automatic test_corners();
		send_pair(32767, 32767);
		send_pair(-32768, -32768);
		send_pair(32767, -32768);
		send_pair(-32768, 32767);
		send_pair(1, 1);
		send_pair(-1, 1);
		send_pair(-1, -1);
		send_pair(1, -1);
	endtask

	// Left half plane near the negative real axis, where the angle may clamp at 180, plus two points off it
	task automatic test_half_turn();
		send_pair(-32768, 1);
		send_pair(-32768, -1);
		send_pair(-32767, 2);
		send_pair(-30000, 20000);
		send_pair(12345, -6789);
	endtask

	// Random field value of a given flavour
	function automatic logic [IO_W-1:0] draw_part(input int unsigned flavour);
		case (flavour)
			0: return 16'($urandom_range(0, 16)) - 16'd8;
			1: begin
				case ($urandom_range(0, 5))
					0: return 16'h8000;
					1: return 16'h8001;
					2: return 16'hffff;
					3: return 16'h0001;
					4: return 16'h7ffe;
					default: return 16'h7fff;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Random samples: mostly full range, some small, on an axis, extreme or near 180
	task automatic test_random();
		sample_t     s;
		int unsigned kind, gap;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				s.real_part = draw_part(2);
				s.imag_part = draw_part(2);
			end else if (kind == 6) begin
				s.real_part = draw_part(0);
				s.imag_part = draw_part(0);
			end else if (kind == 7) begin
				s.real_part = $urandom_range(0, 1) ? draw_part(2) : '0;
				s.imag_part = (s.real_part == '0) ? draw_part(2) : '0;
			end else if (kind == 8) begin
				s.real_part = draw_part(1);
				s.imag_part = draw_part(1);
			end else begin
				s.real_part = 16'(-int'($urandom_range(1, 32768)));
				s.imag_part = 16'($urandom_range(0, 6)) - 16'd3;
			end
			// every third block of a hundred goes back to back
			gap = ((n / 100) % 3 == 0) ? 0 : idle_gap();
			send_sample(s, gap);
		end
	endtask

	// Result side back-pressure: free-running stretches, random stalls, long holds
	int unsigned stall_left = 0;
	int unsigned ready_tick = 0;
	int unsigned ready_roll;
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		ready_roll = $urandom_range(0, 99);
		if (stall_left != 0) begin
			stall_left  <= stall_left - 1;
			polar_ready <= 1'b0;
		end else if ((ready_tick / 200) % 3 == 0) begin
			polar_ready <= 1'b1;
		end else if (ready_roll < 3) begin
			stall_left  <= $urandom_range(20, 50);
			polar_ready <= 1'b0;
		end else begin
			polar_ready <= (ready_roll < 75);
		end
	end

	// Scoreboard: each result against the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && polar_valid && polar_ready) begin
			if (pending_polar.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual magnitude %0d angle %0d",
					$time, polar.magnitude, $signed(polar.angle_deg));
			end else begin
				if (polar.magnitude !== pending_polar[0].want.magnitude) begin
					mismatches++;
					$display("%0t: (%0d,%0d) magnitude expected %0d actual %0d", $time,
						$signed(pending_polar[0].req.real_part),
						$signed(pending_polar[0].req.imag_part),
						pending_polar[0].want.magnitude, polar.magnitude);
				end
				if (polar.angle_deg !== pending_polar[0].want.angle_deg) begin
					mismatches++;
					$display("%0t: (%0d,%0d) angle expected %0d actual %0d", $time,
						$signed(pending_polar[0].req.real_part),
						$signed(pending_polar[0].req.imag_part),
						$signed(pending_polar[0].want.angle_deg),
						$signed(polar.angle_deg));
				end
				void'(pending_polar.pop_front());
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rect_to_polar_converter_test: FAIL");
		$finish;
	end

	// Test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_axes();
		test_corners();
		test_half_turn();
		test_random();
		sample_valid <= 1'b0;
		// drain, then give any stray result time to show up
		while (pending_polar.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("rect_to_polar_converter_test: PASS");
		else
			$display("rect_to_polar_converter_test: FAIL");
		$finish;
	end

endmodule

### rect_to_polar_converter.f
rtl/r2p_pkg.sv
rtl/r2p_cell.sv
rtl/r2p_post.sv
rtl/rect_to_polar_converter.sv
bench/rect_to_polar_converter_test.sv
